// ===== hw/rtl/per_device_interval_gate_assert.svh =====
// Assertion macros for the per-device interval gate.
`ifndef PER_DEVICE_INTERVAL_GATE_ASSERT_SVH
`define PER_DEVICE_INTERVAL_GATE_ASSERT_SVH

// Same-cycle implication, clocked on clk, off during rst.
`define PDIG_ASSERT_NOW(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("pdig check failed");

// Next-cycle implication, clocked on clk, off during rst.
`define PDIG_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("pdig check failed");

`endif

// ===== hw/rtl/pdig_pkg.sv =====
// Shared types and constants for the per-device interval gate.
package pdig_pkg;

  localparam int DATA_W            = 32;
  localparam int TABLE_DEPTH_DEF   = 16;
  localparam int CFG_IDX_W         = 1;
  localparam int DIV_STEPS         = DATA_W + 1;
  localparam int DIV_CNT_W         = $clog2(DIV_STEPS + 1);
  localparam logic [DATA_W-1:0] MS_PER_UNIT = DATA_W'(1000);

  localparam logic REQ_MEAS     = 1'b0;
  localparam logic REQ_QUERY    = 1'b1;
  localparam logic DEV_METER    = 1'b0;
  localparam logic DEV_INVERTER = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_METER_INTERVAL    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERTER_INTERVAL = 1'b1;

  typedef struct packed {
    logic [DATA_W-1:0] interval;
    logic [DATA_W-1:0] remainder;
    logic [DATA_W-1:0] last_time;
    logic              reached;
  } rec_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// ===== hw/rtl/pdig_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pdig_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/pdig_divider.sv =====
// Restoring radix-2 divider, one quotient bit per cycle.
module pdig_divider (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [pdig_pkg::DATA_W:0]     dividend,
  input  logic [pdig_pkg::DATA_W-1:0]   divisor,
  output pdig_pkg::div_status_t         status,
  output logic [pdig_pkg::DATA_W:0]     quotient,
  output logic [pdig_pkg::DATA_W-1:0]   remainder
);

  logic [pdig_pkg::DIV_CNT_W-1:0] cnt;
  logic                           done;
  logic [pdig_pkg::DATA_W:0]      dvd;
  logic [pdig_pkg::DATA_W-1:0]    rem;
  logic [pdig_pkg::DATA_W-1:0]    dsr;
  logic [pdig_pkg::DATA_W:0]      shifted;
  logic [pdig_pkg::DATA_W:0]      diff;
  logic                           qbit;

  assign shifted = {rem, dvd[pdig_pkg::DATA_W]};
  assign diff    = shifted - {1'b0, dsr};
  assign qbit    = (shifted >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= pdig_pkg::DIV_CNT_W'(pdig_pkg::DIV_STEPS);
        dvd <= dividend;
        dsr <= divisor;
        rem <= '0;
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        dvd <= {dvd[pdig_pkg::DATA_W-1:0], qbit};
        rem <= qbit ? diff[pdig_pkg::DATA_W-1:0] : shifted[pdig_pkg::DATA_W-1:0];
        if (cnt == pdig_pkg::DIV_CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  assign status.busy = (cnt != '0);
  assign status.done = done;
  assign quotient    = dvd;
  assign remainder   = rem;

endmodule

// ===== hw/rtl/per_device_interval_gate.sv =====
// Top level: per-device interval gate with table scan and shared divider.
//
//   channel | signals                                        | dir
//   --------+------------------------------------------------+-----
//   in      | in_valid in_ready req_type dev_id              | in
//           | dev_kind timestamp                             |
//   out     | out_valid out_ready pass known table_full      | out
//   cfg     | cfg_valid cfg_ready cfg_index cfg_data         | in
//
// One request reads and compares each table entry scanned (RAM read, compare),
// uses the shared divider when a remainder wraps or an inverter entry is
// allocated, and passes through setup and output states.
// Reset clears the fill count and config; no clearing pass is needed.
// in_ready is low while a request is in work; a result waiting on out_ready
// holds the sequencer, but the next request is taken once it is registered.
module per_device_interval_gate #(
  parameter int TABLE_DEPTH = pdig_pkg::TABLE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            req_type,
  input  logic [pdig_pkg::DATA_W-1:0]     dev_id,
  input  logic                            dev_kind,
  input  logic [pdig_pkg::DATA_W-1:0]     timestamp,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            pass,
  output logic                            known,
  output logic                            table_full,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pdig_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pdig_pkg::DATA_W-1:0]     cfg_data
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int DW    = pdig_pkg::DATA_W;
  localparam int REC_W = $bits(pdig_pkg::rec_t);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD    = 3'd1;
  localparam logic [2:0] S_CMP   = 3'd2;
  localparam logic [2:0] S_UPD   = 3'd3;
  localparam logic [2:0] S_MOD   = 3'd4;
  localparam logic [2:0] S_MISS  = 3'd5;
  localparam logic [2:0] S_ALLOC = 3'd6;
  localparam logic [2:0] S_EMIT  = 3'd7;

  logic [2:0]       state, state_next;
  logic [IDX_W-1:0] addr, addr_next;
  logic [CNT_W-1:0] count, count_next;
  logic [DW-1:0]    meter_interval;
  logic [DW-1:0]    inverter_interval_ms;

  logic             req_q;
  logic [DW-1:0]    serial_q;
  logic             dtype_q;
  logic [DW-1:0]    ts_q;

  logic             res_pass, res_pass_next;
  logic             res_known, res_known_next;
  logic             res_full, res_full_next;

  logic [DW-1:0]    rd_serial;
  pdig_pkg::rec_t   rd_rec;
  logic [REC_W-1:0] rd_rec_bits;
  pdig_pkg::rec_t   wr_rec;
  logic             we_serial;
  logic             we_rec;
  logic [IDX_W-1:0] waddr;

  logic                  div_start;
  logic [DW:0]           div_dividend;
  logic [DW-1:0]         div_divisor;
  pdig_pkg::div_status_t div_status;
  logic [DW:0]           div_quot;
  logic [DW-1:0]         div_rem;

  logic [DW-1:0]    diff;
  logic [DW:0]      sum;
  logic [DW-1:0]    alloc_ivl;

  assign rd_rec = pdig_pkg::rec_t'(rd_rec_bits);
  assign diff   = ts_q - rd_rec.last_time;
  assign sum    = {1'b0, rd_rec.remainder} + {1'b0, diff};

  pdig_ram #(.WIDTH(DW), .DEPTH(TABLE_DEPTH), .AW(IDX_W)) u_serial_ram (
    .clk   (clk),
    .we    (we_serial),
    .waddr (waddr),
    .wdata (serial_q),
    .raddr (addr),
    .rdata (rd_serial)
  );

  pdig_ram #(.WIDTH(REC_W), .DEPTH(TABLE_DEPTH), .AW(IDX_W)) u_rec_ram (
    .clk   (clk),
    .we    (we_rec),
    .waddr (waddr),
    .wdata (wr_rec),
    .raddr (addr),
    .rdata (rd_rec_bits)
  );

  pdig_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .status    (div_status),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  always_comb begin
    state_next     = state;
    addr_next      = addr;
    count_next     = count;
    res_pass_next  = res_pass;
    res_known_next = res_known;
    res_full_next  = res_full;
    we_serial      = 1'b0;
    we_rec         = 1'b0;
    waddr          = addr;
    wr_rec         = rd_rec;
    div_start      = 1'b0;
    div_dividend   = sum;
    div_divisor    = rd_rec.interval;
    alloc_ivl      = (state == S_ALLOC) ? div_quot[DW-1:0] : meter_interval;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          addr_next  = '0;
          state_next = (count == '0) ? S_MISS : S_RD;
        end
      end
      S_RD: begin
        state_next = S_CMP;
      end
      S_CMP: begin
        if (rd_serial == serial_q) begin
          res_known_next = 1'b1;
          res_full_next  = 1'b0;
          if (req_q == pdig_pkg::REQ_QUERY) begin
            res_pass_next = rd_rec.reached;
            state_next    = S_EMIT;
          end else begin
            state_next = S_UPD;
          end
        end else if (CNT_W'(addr) + 1'b1 == count) begin
          state_next = S_MISS;
        end else begin
          addr_next  = addr + 1'b1;
          state_next = S_RD;
        end
      end
      S_UPD: begin
        state_next = S_EMIT;
        if (rd_rec.interval == '0) begin
          we_rec           = 1'b1;
          wr_rec.last_time = ts_q;
          wr_rec.reached   = 1'b1;
          res_pass_next    = 1'b1;
        end else if (ts_q == rd_rec.last_time) begin
          res_pass_next = rd_rec.reached;
        end else if (sum >= {1'b0, rd_rec.interval}) begin
          div_start  = 1'b1;
          state_next = S_MOD;
        end else begin
          we_rec           = 1'b1;
          wr_rec.remainder = sum[DW-1:0];
          wr_rec.last_time = ts_q;
          wr_rec.reached   = 1'b0;
          res_pass_next    = 1'b0;
        end
      end
      S_MOD: begin
        if (div_status.done) begin
          we_rec           = 1'b1;
          wr_rec.remainder = div_rem;
          wr_rec.last_time = ts_q;
          wr_rec.reached   = 1'b1;
          res_pass_next    = 1'b1;
          state_next       = S_EMIT;
        end
      end
      S_MISS, S_ALLOC: begin
        if (state == S_MISS && req_q == pdig_pkg::REQ_QUERY) begin
          res_pass_next  = 1'b0;
          res_known_next = 1'b0;
          res_full_next  = 1'b0;
          state_next     = S_EMIT;
        end else if (state == S_MISS && count == CNT_W'(TABLE_DEPTH)) begin
          res_pass_next  = 1'b1;
          res_known_next = 1'b0;
          res_full_next  = 1'b1;
          state_next     = S_EMIT;
        end else if (state == S_MISS && dtype_q == pdig_pkg::DEV_INVERTER) begin
          div_start    = 1'b1;
          div_dividend = {1'b0, inverter_interval_ms};
          div_divisor  = pdig_pkg::MS_PER_UNIT;
          state_next   = S_ALLOC;
        end else if (state == S_MISS || div_status.done) begin
          we_serial        = 1'b1;
          we_rec           = 1'b1;
          waddr            = count[IDX_W-1:0];
          wr_rec.interval  = alloc_ivl;
          wr_rec.remainder = '0;
          wr_rec.last_time = ts_q;
          wr_rec.reached   = (alloc_ivl == '0);
          count_next       = count + 1'b1;
          res_pass_next    = (alloc_ivl == '0);
          res_known_next   = 1'b1;
          res_full_next    = 1'b0;
          state_next       = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state                <= S_IDLE;
      count                <= '0;
      out_valid            <= 1'b0;
      meter_interval       <= '0;
      inverter_interval_ms <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (cfg_valid) begin
        case (cfg_index)
          pdig_pkg::CFG_METER_INTERVAL:    meter_interval       <= cfg_data;
          pdig_pkg::CFG_INVERTER_INTERVAL: inverter_interval_ms <= cfg_data;
          default: ;
        endcase
      end
      if (state == S_EMIT && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    addr      <= addr_next;
    res_pass  <= res_pass_next;
    res_known <= res_known_next;
    res_full  <= res_full_next;
    if (state == S_IDLE && in_valid) begin
      req_q    <= req_type;
      serial_q <= dev_id;
      dtype_q  <= dev_kind;
      ts_q     <= timestamp;
    end
    if (state == S_EMIT && (!out_valid || out_ready)) begin
      pass       <= res_pass;
      known      <= res_known;
      table_full <= res_full;
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

`include "per_device_interval_gate_assert.svh"

  `PDIG_ASSERT_NOW(a_idle_div_quiet, in_ready, !div_status.busy)
  `PDIG_ASSERT_NOW(a_count_bound, 1'b1, count <= CNT_W'(TABLE_DEPTH))
  `PDIG_ASSERT_NOW(a_full_result, out_valid && table_full, pass && !known)
  `PDIG_ASSERT_NEXT(a_count_hold, !(state == S_MISS || state == S_ALLOC), $stable(count))

endmodule

// ===== tb/sv/per_device_interval_gate_checker.sv =====
// Checker for the per-device interval gate: predicts each decision and compares results.
module per_device_interval_gate_checker #(
  parameter int DEPTH = pdig_pkg::TABLE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic                            req_type,
  input  logic [pdig_pkg::DATA_W-1:0]     dev_id,
  input  logic                            dev_kind,
  input  logic [pdig_pkg::DATA_W-1:0]     timestamp,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic                            pass,
  input  logic                            known,
  input  logic                            table_full,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [pdig_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pdig_pkg::DATA_W-1:0]     cfg_data,
  output int                              outstanding,
  output int                              mismatches
);

  localparam int DW = pdig_pkg::DATA_W;

  typedef struct packed {
    logic pass;
    logic known;
    logic full;
  } verdict_t;

  logic [DW-1:0] meter_ivl;
  logic [DW-1:0] inverter_ms;

  logic          dev_used    [DEPTH];
  logic [DW-1:0] dev_serial  [DEPTH];
  logic [DW-1:0] dev_ivl     [DEPTH];
  logic [DW-1:0] dev_rem     [DEPTH];
  logic [DW-1:0] dev_last    [DEPTH];
  logic          dev_reached [DEPTH];

  verdict_t decision_q[$];
  int errs = 0;

  task automatic gate_decision(input logic rq, input logic [DW-1:0] sn, input logic dt,
                               input logic [DW-1:0] ts, output verdict_t v);
    int hit;
    int slot;
    logic fresh;
    logic [DW-1:0] gap;
    logic [DW:0] sum;
    logic [DW:0] ivl;
    hit = -1;
    slot = -1;
    fresh = 1'b0;
    v = '0;
    for (int i = 0; i < DEPTH; i++)
      if (hit < 0 && dev_used[i] && dev_serial[i] == sn) hit = i;
    if (rq == pdig_pkg::REQ_QUERY) begin
      if (hit >= 0) begin
        v.known = 1'b1;
        v.pass = dev_reached[hit];
      end
    end else begin
      if (hit < 0) begin
        for (int i = 0; i < DEPTH; i++)
          if (slot < 0 && !dev_used[i]) slot = i;
        if (slot >= 0) begin
          hit = slot;
          dev_used[hit] = 1'b1;
          dev_serial[hit] = sn;
          dev_ivl[hit] = (dt == pdig_pkg::DEV_INVERTER) ?
                         inverter_ms / pdig_pkg::MS_PER_UNIT : meter_ivl;
          dev_rem[hit] = '0;
          dev_last[hit] = '0;
          dev_reached[hit] = 1'b0;
          fresh = 1'b1;
        end
      end
      if (hit < 0) begin
        v.full = 1'b1;
        v.pass = 1'b1;
      end else begin
        v.known = 1'b1;
        if (dev_ivl[hit] == '0) begin
          dev_reached[hit] = 1'b1;
        end else if (fresh) begin
          dev_reached[hit] = 1'b0;
        end else if (ts != dev_last[hit]) begin
          gap = ts - dev_last[hit];
          sum = {1'b0, dev_rem[hit]} + {1'b0, gap};
          ivl = {1'b0, dev_ivl[hit]};
          if (sum >= ivl) begin
            dev_reached[hit] = 1'b1;
            dev_rem[hit] = DW'(sum % ivl);
          end else begin
            dev_reached[hit] = 1'b0;
            dev_rem[hit] = sum[DW-1:0];
          end
        end
        dev_last[hit] = ts;
        v.pass = dev_reached[hit];
      end
    end
  endtask

  task automatic check_bit(input string field, input logic exp, input logic act);
    if (act !== exp) begin
      $error("%s: expected %0b, got %0b", field, exp, act);
      errs++;
    end
  endtask

  always @(posedge clk) begin : watch_b
    verdict_t want;
    if (rst) begin
      meter_ivl = '0;
      inverter_ms = '0;
      for (int i = 0; i < DEPTH; i++) dev_used[i] = 1'b0;
      decision_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          pdig_pkg::CFG_METER_INTERVAL:    meter_ivl = cfg_data;
          pdig_pkg::CFG_INVERTER_INTERVAL: inverter_ms = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (decision_q.size() == 0) begin
          $error("result with no request waiting: pass %0b known %0b table_full %0b",
                 pass, known, table_full);
          errs++;
        end else begin
          want = decision_q.pop_front();
          check_bit("pass", want.pass, pass);
          check_bit("known", want.known, known);
          check_bit("table_full", want.full, table_full);
        end
      end
      if (in_valid && in_ready) begin
        gate_decision(req_type, dev_id, dev_kind, timestamp, want);
        decision_q = {decision_q, want};
      end
    end
    outstanding <= decision_q.size();
    mismatches <= errs;
  end

endmodule

// ===== tb/sv/per_device_interval_gate_tb.sv =====
// Testbench top for the per-device interval gate: stimulus, idling and verdict.
module per_device_interval_gate_tb;

  localparam int DW           = pdig_pkg::DATA_W;
  localparam int CW           = pdig_pkg::CFG_IDX_W;
  localparam int DEPTH        = pdig_pkg::TABLE_DEPTH_DEF;
  localparam int PHASES       = 7;
  localparam int RANDOM_ITEMS = 1250;
  localparam int NEW_PER_PHASE = 2;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           in_valid = 1'b0;
  logic           in_ready;
  logic           req_type = pdig_pkg::REQ_MEAS;
  logic [DW-1:0]  dev_id = '0;
  logic           dev_kind = pdig_pkg::DEV_METER;
  logic [DW-1:0]  timestamp = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  logic           pass;
  logic           known;
  logic           table_full;
  logic           cfg_valid = 1'b0;
  logic           cfg_ready;
  logic [CW-1:0]  cfg_index = pdig_pkg::CFG_METER_INTERVAL;
  logic [DW-1:0]  cfg_data = '0;

  int   outstanding;
  int   mismatches;
  logic calm = 1'b0;

  logic [DW-1:0] roster_sn [DEPTH];
  logic [DW-1:0] roster_ts [DEPTH];
  int            roster_count = 0;

  per_device_interval_gate #(.TABLE_DEPTH(DEPTH)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .dev_id(dev_id),
    .dev_kind(dev_kind), .timestamp(timestamp),
    .out_valid(out_valid), .out_ready(out_ready),
    .pass(pass), .known(known), .table_full(table_full),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  per_device_interval_gate_checker #(.DEPTH(DEPTH)) monitor (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .dev_id(dev_id),
    .dev_kind(dev_kind), .timestamp(timestamp),
    .out_valid(out_valid), .out_ready(out_ready),
    .pass(pass), .known(known), .table_full(table_full),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .outstanding(outstanding), .mismatches(mismatches)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("per_device_interval_gate: mismatch");
    $finish;
  end

  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 36);
  end

  function automatic bit on_roster(input logic [DW-1:0] sn);
    for (int i = 0; i < roster_count; i++)
      if (roster_sn[i] == sn) return 1'b1;
    return 1'b0;
  endfunction

  function automatic logic [DW-1:0] fresh_serial();
    logic [DW-1:0] sn;
    do sn = $urandom; while (on_roster(sn));
    return sn;
  endfunction

  function automatic logic [DW-1:0] next_stamp(input logic [DW-1:0] last);
    int k;
    k = $urandom_range(99);
    if (k < 15) return last;
    if (k < 45) return last + $urandom_range(1, 8);
    if (k < 70) return last + $urandom_range(1, 700);
    if (k < 80) return last + $urandom_range(1000, 5_000_000);
    if (k < 88) return $urandom;
    if (k < 94) return last - 1;
    return last - $urandom_range(1, 50);
  endfunction

  task automatic send_req(input logic rq, input logic [DW-1:0] sn, input logic dt,
                          input logic [DW-1:0] ts);
    while (!calm && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= rq;
    dev_id <= sn;
    dev_kind <= dt;
    timestamp <= ts;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // new device: measurement that allocates while the table has room
  task automatic enroll(input logic [DW-1:0] sn, input logic dt, input logic [DW-1:0] ts);
    if (roster_count < DEPTH) begin
      roster_sn[roster_count] = sn;
      roster_ts[roster_count] = ts;
      roster_count++;
    end
    send_req(pdig_pkg::REQ_MEAS, sn, dt, ts);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CW-1:0] idx, input logic [DW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_phase(input int items, input int new_devs);
    int added;
    int pick;
    int d;
    logic [DW-1:0] sn;
    logic [DW-1:0] ts;
    added = 0;
    repeat (items) begin
      pick = $urandom_range(99);
      if (pick < 10 && (roster_count == DEPTH || added < new_devs)) begin
        if (roster_count < DEPTH) added++;
        enroll(fresh_serial(), 1'($urandom_range(1)), $urandom);
      end else if (pick < 20 || roster_count == 0) begin
        if ($urandom_range(1) && roster_count > 0)
          sn = roster_sn[$urandom_range(roster_count - 1)];
        else
          sn = fresh_serial();
        send_req(pdig_pkg::REQ_QUERY, sn, 1'($urandom_range(1)), $urandom);
      end else begin
        d = $urandom_range(roster_count - 1);
        ts = next_stamp(roster_ts[d]);
        roster_ts[d] = ts;
        send_req(pdig_pkg::REQ_MEAS, roster_sn[d], 1'($urandom_range(1)), ts);
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // zero intervals after reset: every measurement passes
    send_req(pdig_pkg::REQ_QUERY, 32'h0000_0000, pdig_pkg::DEV_METER, 32'h0000_0000);
    enroll(32'h0000_0000, pdig_pkg::DEV_METER, 32'h0000_0000);
    send_req(pdig_pkg::REQ_MEAS, 32'h0000_0000, pdig_pkg::DEV_INVERTER, 32'h0000_0000);
    send_req(pdig_pkg::REQ_QUERY, 32'h0000_0000, pdig_pkg::DEV_METER, 32'hFFFF_FFFF);
    enroll(32'hFFFF_FFFF, pdig_pkg::DEV_INVERTER, 32'hFFFF_FFFF);
    send_req(pdig_pkg::REQ_MEAS, 32'hFFFF_FFFF, pdig_pkg::DEV_METER, 32'h0000_0000);
    settle();

    write_reg(pdig_pkg::CFG_METER_INTERVAL, 32'd7);
    write_reg(pdig_pkg::CFG_INVERTER_INTERVAL, 32'd5500);
    enroll(32'h1234_5678, pdig_pkg::DEV_METER, 32'd100);
    send_req(pdig_pkg::REQ_QUERY, 32'h1234_5678, pdig_pkg::DEV_METER, 32'd0);
    send_req(pdig_pkg::REQ_MEAS, 32'h1234_5678, pdig_pkg::DEV_METER, 32'd103);
    send_req(pdig_pkg::REQ_MEAS, 32'h1234_5678, pdig_pkg::DEV_METER, 32'd103);
    send_req(pdig_pkg::REQ_MEAS, 32'h1234_5678, pdig_pkg::DEV_METER, 32'd110);
    send_req(pdig_pkg::REQ_MEAS, 32'h1234_5678, pdig_pkg::DEV_INVERTER, 32'd110);
    send_req(pdig_pkg::REQ_QUERY, 32'h1234_5678, pdig_pkg::DEV_METER, 32'd0);
    // backward timestamp wraps
    send_req(pdig_pkg::REQ_MEAS, 32'h1234_5678, pdig_pkg::DEV_METER, 32'd50);
    roster_ts[2] = 32'd50;
    enroll(32'hA5A5_A5A5, pdig_pkg::DEV_INVERTER, 32'd0);
    send_req(pdig_pkg::REQ_MEAS, 32'hA5A5_A5A5, pdig_pkg::DEV_INVERTER, 32'd4);
    send_req(pdig_pkg::REQ_MEAS, 32'hA5A5_A5A5, pdig_pkg::DEV_INVERTER, 32'd5);
    send_req(pdig_pkg::REQ_QUERY, 32'hA5A5_A5A5, pdig_pkg::DEV_INVERTER, 32'd5);
    send_req(pdig_pkg::REQ_QUERY, 32'h5A5A_5A5A, pdig_pkg::DEV_INVERTER, 32'hFFFF_FFFF);
    roster_ts[3] = 32'd5;

    for (int p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        0: begin
          write_reg(pdig_pkg::CFG_METER_INTERVAL, 32'd3);
          write_reg(pdig_pkg::CFG_INVERTER_INTERVAL, 32'd2000);
        end
        1: begin
          write_reg(pdig_pkg::CFG_METER_INTERVAL, 32'hFFFF_FFFF);
          write_reg(pdig_pkg::CFG_INVERTER_INTERVAL, 32'hFFFF_FFFF);
        end
        2: begin
          write_reg(pdig_pkg::CFG_METER_INTERVAL, 32'd1);
          write_reg(pdig_pkg::CFG_INVERTER_INTERVAL, 32'd999);
        end
        3: begin
          write_reg(pdig_pkg::CFG_METER_INTERVAL, 32'd0);
          write_reg(pdig_pkg::CFG_INVERTER_INTERVAL, 32'd1000);
        end
        4: begin
          write_reg(pdig_pkg::CFG_METER_INTERVAL, $urandom_range(1, 500));
          write_reg(pdig_pkg::CFG_INVERTER_INTERVAL, $urandom_range(0, 600_000));
        end
        5: begin
          write_reg(pdig_pkg::CFG_METER_INTERVAL, $urandom);
          write_reg(pdig_pkg::CFG_INVERTER_INTERVAL, $urandom);
        end
        default: begin
          write_reg(pdig_pkg::CFG_METER_INTERVAL, $urandom_range(1, 40));
          write_reg(pdig_pkg::CFG_INVERTER_INTERVAL, $urandom_range(1000, 40_000));
        end
      endcase
      calm <= (p == 2);
      random_phase(RANDOM_ITEMS / PHASES, NEW_PER_PHASE);
    end

    settle();
    repeat (100) @(posedge clk);
    if (mismatches == 0)
      $display("per_device_interval_gate: match");
    else
      $display("per_device_interval_gate: mismatch");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/pdig_pkg.sv
hw/rtl/pdig_ram.sv
hw/rtl/pdig_divider.sv
hw/rtl/per_device_interval_gate.sv
tb/sv/per_device_interval_gate_checker.sv
tb/sv/per_device_interval_gate_tb.sv
